[rtl/spdc_pkg.sv]
// shared types, constants and the control program of the servo pd controller
// no dependencies; imported by spdc_div and servo_position_pd_controller_core
package spdc_pkg;

    // widths
    localparam int POSITION_BITS_DEFAULT = 12;
    localparam int STATE_BITS            = 16;
    localparam int ACC_BITS              = 32;
    localparam int MUL_A_BITS            = 20;
    localparam int MUL_B_BITS            = 12;
    localparam int DRIVE_BITS            = 11;
    localparam int SEEK_BITS             = 11;
    localparam int SPEED_BITS            = 9;
    localparam int DIVISOR_BITS          = 10;

    // divider: 30 bit magnitude, two quotient bits a cycle
    localparam int DIV_BITS       = 30;
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_CYCLES     = DIV_BITS / DIV_RADIX_BITS;
    localparam int DIV_CNT_BITS   = $clog2(DIV_CYCLES + 1);

    // gains and scaling
    localparam int P_GAIN      = 300;
    localparam int D_GAIN      = 255;
    localparam int DRIVE_SHIFT = 8;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 13;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_LIMIT  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_LIMIT  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEADBAND   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPEED_MAX  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_OUTPUT = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_OUTPUT = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPAN       = 3'd6;

    // register reset values
    localparam logic [11:0]        RST_MIN_LIMIT  = 12'd0;
    localparam logic [11:0]        RST_MAX_LIMIT  = 12'd4095;
    localparam logic [7:0]         RST_DEADBAND   = 8'd1;
    localparam logic [9:0]         RST_SPEED_MAX  = 10'd100;
    localparam logic [9:0]         RST_MAX_OUTPUT = 10'd255;
    localparam logic signed [10:0] RST_MIN_OUTPUT = -11'sd255;
    localparam logic [12:0]        RST_SPAN       = 13'd4096;

    // micro-operations of the datapath
    typedef enum logic [3:0] {
        U_NOP,
        U_VEL,
        U_WRAP,
        U_DT_PRE,
        U_MUL_255,
        U_MUL_300,
        U_MUL_SEEK,
        U_MUL_SPD,
        U_DIV_SM,
        U_DIV_255,
        U_DT_SAT,
        U_LIMIT,
        U_ADD_D,
        U_CLEAR,
        U_OUT,
        U_SET
    } uop_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_ITEM,
        C_SET_OP,
        C_DIV_BUSY,
        C_IN_BAND,
        C_OUT_BUSY
    } cond_t;

    // program addresses
    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_VEL,
        S_WRAP,
        S_DT_PRE,
        S_DT_MUL,
        S_DT_DIV,
        S_DT_WAIT,
        S_DT_SAT,
        S_P_MUL,
        S_P_LIM,
        S_P_SCALE,
        S_P_DIV,
        S_P_WAIT,
        S_P_ADD,
        S_ZERO,
        S_FINAL,
        S_OUT_WAIT,
        S_OUT,
        S_SPD_MUL,
        S_SPD_DIV,
        S_SPD_WAIT,
        S_SET
    } step_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        step_t target;
    } ctrl_t;

    // control store: jump to target when cond holds, else fall through
    function automatic ctrl_t ucode(step_t s);
        ctrl_t w;
        unique case (s)
            S_IDLE:     w = '{uop: U_NOP,      cond: C_NO_ITEM,  target: S_IDLE};
            S_DISPATCH: w = '{uop: U_NOP,      cond: C_SET_OP,   target: S_SPD_MUL};
            S_VEL:      w = '{uop: U_VEL,      cond: C_NEXT,     target: S_IDLE};
            S_WRAP:     w = '{uop: U_WRAP,     cond: C_NEXT,     target: S_IDLE};
            S_DT_PRE:   w = '{uop: U_DT_PRE,   cond: C_NEXT,     target: S_IDLE};
            S_DT_MUL:   w = '{uop: U_MUL_255,  cond: C_NEXT,     target: S_IDLE};
            S_DT_DIV:   w = '{uop: U_DIV_SM,   cond: C_NEXT,     target: S_IDLE};
            S_DT_WAIT:  w = '{uop: U_NOP,      cond: C_DIV_BUSY, target: S_DT_WAIT};
            S_DT_SAT:   w = '{uop: U_DT_SAT,   cond: C_IN_BAND,  target: S_ZERO};
            S_P_MUL:    w = '{uop: U_MUL_300,  cond: C_NEXT,     target: S_IDLE};
            S_P_LIM:    w = '{uop: U_LIMIT,    cond: C_NEXT,     target: S_IDLE};
            S_P_SCALE:  w = '{uop: U_MUL_SEEK, cond: C_NEXT,     target: S_IDLE};
            S_P_DIV:    w = '{uop: U_DIV_SM,   cond: C_NEXT,     target: S_IDLE};
            S_P_WAIT:   w = '{uop: U_NOP,      cond: C_DIV_BUSY, target: S_P_WAIT};
            S_P_ADD:    w = '{uop: U_ADD_D,    cond: C_ALWAYS,   target: S_FINAL};
            S_ZERO:     w = '{uop: U_CLEAR,    cond: C_NEXT,     target: S_IDLE};
            S_FINAL:    w = '{uop: U_LIMIT,    cond: C_NEXT,     target: S_IDLE};
            S_OUT_WAIT: w = '{uop: U_NOP,      cond: C_OUT_BUSY, target: S_OUT_WAIT};
            S_OUT:      w = '{uop: U_OUT,      cond: C_ALWAYS,   target: S_IDLE};
            S_SPD_MUL:  w = '{uop: U_MUL_SPD,  cond: C_NEXT,     target: S_IDLE};
            S_SPD_DIV:  w = '{uop: U_DIV_255,  cond: C_NEXT,     target: S_IDLE};
            S_SPD_WAIT: w = '{uop: U_NOP,      cond: C_DIV_BUSY, target: S_SPD_WAIT};
            S_SET:      w = '{uop: U_SET,      cond: C_ALWAYS,   target: S_IDLE};
            default:    w = '{uop: U_NOP,      cond: C_ALWAYS,   target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

[rtl/spdc_div.sv]
// iterative signed divider, truncating toward zero, two quotient bits a cycle
// depends on spdc_pkg for widths and cycle count
module spdc_div (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic signed [spdc_pkg::ACC_BITS-1:0]       dividend,
    input  logic        [spdc_pkg::DIVISOR_BITS-1:0]   divisor,
    output logic                                       busy,
    output logic signed [spdc_pkg::ACC_BITS-1:0]       quotient
);
    import spdc_pkg::*;

    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DIV_BITS-1:0]     quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0] rem_reg, rem_next;
    logic [DIVISOR_BITS-1:0] dvs_reg, dvs_next;
    logic                    neg_reg, neg_next;
    logic [ACC_BITS-1:0]     mag;
    logic [DIVISOR_BITS:0]   trial;
    logic [ACC_BITS-1:0]     quo_ext;

    always_comb
    begin
        mag      = dividend[ACC_BITS-1] ? ACC_BITS'(-dividend) : ACC_BITS'(dividend);
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        neg_next = neg_reg;
        trial    = '0;
        if (start)
        begin
            quo_next = mag[DIV_BITS-1:0];
            rem_next = '0;
            dvs_next = divisor;
            neg_next = dividend[ACC_BITS-1];
            cnt_next = DIV_CNT_BITS'(DIV_CYCLES);
        end
        else if (cnt_reg != '0)
        begin
            // restoring steps, msb first
            for (int i = 0; i < DIV_RADIX_BITS; i++)
            begin
                trial    = {rem_next, quo_next[DIV_BITS-1]};
                quo_next = {quo_next[DIV_BITS-2:0], 1'b0};
                if (trial >= {1'b0, dvs_reg})
                begin
                    trial       = trial - {1'b0, dvs_reg};
                    quo_next[0] = 1'b1;
                end
                rem_next = trial[DIVISOR_BITS-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quo_ext  = ACC_BITS'(quo_reg);
    assign quotient = neg_reg ? -signed'(quo_ext) : signed'(quo_ext);

endmodule

[rtl/servo_position_pd_controller_core.sv]
// servo position pd controller with deadband, microcoded over one multiplier and one divider
// words are handled one at a time; a sample word outside the deadband uses the shared divider twice
// the next word is taken as soon as the program returns to idle, while a drive word may still wait
// reset: asynchronous active low; registers take their reset values, state clears to zero
// depends on spdc_pkg and spdc_div
module servo_position_pd_controller_core #(
    parameter int POSITION_BITS = spdc_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // configuration
    input  logic                                      cfg_write,
    input  logic [spdc_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [spdc_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    // input words
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic                                      operation,
    input  logic signed [spdc_pkg::STATE_BITS-1:0]    target_position,
    input  logic signed [spdc_pkg::SPEED_BITS-1:0]    command_speed,
    input  logic        [POSITION_BITS-1:0]           position_sample,
    // result words
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [spdc_pkg::DRIVE_BITS-1:0]    drive
);
    import spdc_pkg::*;

    // configuration registers
    logic [11:0]        min_lim_reg;
    logic [11:0]        max_lim_reg;
    logic [7:0]         band_reg;
    logic [9:0]         speed_max_reg;
    logic [9:0]         max_out_reg;
    logic signed [10:0] min_out_reg;
    logic [12:0]        span_reg;

    // sequencer
    step_t step_reg, step_next;
    ctrl_t ctrl;
    logic  taken;
    logic  accept;

    // latched input word
    logic                         op_reg;
    logic signed [STATE_BITS-1:0] tgt_in_reg;
    logic signed [SPEED_BITS-1:0] spd_in_reg;
    logic signed [STATE_BITS-1:0] smp_reg;

    // controller state
    logic signed [STATE_BITS-1:0] prev_reg, prev_next;
    logic signed [STATE_BITS-1:0] target_reg, target_next;
    logic [SEEK_BITS-1:0]         seek_reg, seek_next;

    // working registers
    logic signed [STATE_BITS-1:0] vel_reg, vel_next;
    logic signed [STATE_BITS-1:0] err_reg, err_next;
    logic signed [STATE_BITS-1:0] dterm_reg, dterm_next;
    logic signed [ACC_BITS-1:0]   acc_reg, acc_next;

    // result register
    logic                         out_valid_reg, out_valid_next;
    logic signed [DRIVE_BITS-1:0] drive_reg, drive_next;

    // datapath helpers
    logic [DIVISOR_BITS-1:0]      sm;
    logic signed [STATE_BITS-1:0] min_lim_s, max_lim_s;
    logic signed [STATE_BITS-1:0] clamp_lo, clamp_t;
    logic signed [STATE_BITS-1:0] vel_diff;
    logic signed [17:0]           vel_w, vel_adj, half_s, span_s, seek_s, seek_sel;
    logic signed [16:0]           err_ext;
    logic [16:0]                  err_mag;
    logic                         in_band, dt_band;
    logic signed [9:0]            spd_ext, spd_mag;
    logic signed [MUL_A_BITS-1:0] mul_a;
    logic signed [MUL_B_BITS-1:0] mul_b;
    logic signed [ACC_BITS-1:0]   mul_p;
    logic signed [ACC_BITS-1:0]   hi_lim, lo_lim, limited;
    logic signed [ACC_BITS-1:0]   rounded, scaled;

    // divider hookup
    logic                         div_start;
    logic [DIVISOR_BITS-1:0]      div_divisor;
    logic                         div_busy;
    logic signed [ACC_BITS-1:0]   div_quo;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_lim_reg   <= RST_MIN_LIMIT;
            max_lim_reg   <= RST_MAX_LIMIT;
            band_reg      <= RST_DEADBAND;
            speed_max_reg <= RST_SPEED_MAX;
            max_out_reg   <= RST_MAX_OUTPUT;
            min_out_reg   <= RST_MIN_OUTPUT;
            span_reg      <= RST_SPAN;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MIN_LIMIT:  min_lim_reg   <= cfg_data[11:0];
                REG_MAX_LIMIT:  max_lim_reg   <= cfg_data[11:0];
                REG_DEADBAND:   band_reg      <= cfg_data[7:0];
                REG_SPEED_MAX:  speed_max_reg <= cfg_data[9:0];
                REG_MAX_OUTPUT: max_out_reg   <= cfg_data[9:0];
                REG_MIN_OUTPUT: min_out_reg   <= signed'(cfg_data[10:0]);
                REG_SPAN:       span_reg      <= cfg_data[12:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer: control word from the program, step counter with jumps
    // ------------------------------------------------------------------
    assign ctrl     = ucode(step_reg);
    assign in_stall = (step_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        unique case (ctrl.cond)
            C_NEXT:     taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_NO_ITEM:  taken = !in_valid;
            C_SET_OP:   taken = !op_reg;
            C_DIV_BUSY: taken = div_busy;
            C_IN_BAND:  taken = in_band;
            C_OUT_BUSY: taken = out_valid_reg && out_stall;
            default:    taken = 1'b1;
        endcase
        step_next = taken ? ctrl.target : step_t'(step_reg + 1'b1);
    end

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    // a zero full-scale speed divides by one
    assign sm = (speed_max_reg == '0) ? DIVISOR_BITS'(1) : speed_max_reg;

    // target clamp: raise to min, then lower to max so max wins
    assign min_lim_s = signed'(STATE_BITS'(min_lim_reg));
    assign max_lim_s = signed'(STATE_BITS'(max_lim_reg));
    assign clamp_lo  = (target_reg < min_lim_s) ? min_lim_s : target_reg;
    assign clamp_t   = (clamp_lo > max_lim_s) ? max_lim_s : clamp_lo;

    // velocity, wrapped to 16 bits and then into half the span
    assign vel_diff = smp_reg - prev_reg;
    assign vel_w    = 18'(vel_reg);
    assign half_s   = signed'(18'(span_reg >> 1));
    assign span_s   = signed'(18'(span_reg));

    always_comb
    begin
        if (vel_w > half_s)
        begin
            vel_adj = vel_w - span_s;
        end
        else if (vel_w < -half_s)
        begin
            vel_adj = vel_w + span_s;
        end
        else
        begin
            vel_adj = vel_w;
        end
    end

    // error magnitude against the deadband and four times the deadband
    assign err_ext = 17'(err_reg);
    assign err_mag = err_reg[STATE_BITS-1] ? 17'(-err_ext) : 17'(err_ext);
    assign in_band = (err_mag <= 17'(band_reg));
    assign dt_band = (err_mag <= 17'({band_reg, 2'b00}));

    // seek speed signed by the error direction
    assign seek_s   = signed'(18'(seek_reg));
    assign seek_sel = (err_reg > 0) ? seek_s : -seek_s;

    // speed magnitude for the set word
    assign spd_ext = 10'(spd_in_reg);
    assign spd_mag = spd_in_reg[SPEED_BITS-1] ? -spd_ext : spd_ext;

    // drive limits scaled by 256
    assign hi_lim  = ACC_BITS'(signed'({1'b0, max_out_reg, 8'b0}));
    assign lo_lim  = ACC_BITS'(signed'({min_out_reg, 8'b0}));
    assign limited = (acc_reg > hi_lim) ? hi_lim :
                     ((acc_reg < lo_lim) ? lo_lim : acc_reg);

    // final divide by 256, truncating toward zero
    assign rounded = acc_reg + (acc_reg[ACC_BITS-1] ?
                     ACC_BITS'((1 << DRIVE_SHIFT) - 1) : ACC_BITS'(0));
    assign scaled  = rounded >>> DRIVE_SHIFT;

    // shared multiplier, operands picked by the micro-op
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.uop)
            U_MUL_SPD:
            begin
                mul_a = MUL_A_BITS'(spd_mag);
                mul_b = signed'(MUL_B_BITS'(speed_max_reg));
            end
            U_MUL_255:
            begin
                mul_a = acc_reg[MUL_A_BITS-1:0];
                mul_b = MUL_B_BITS'(D_GAIN);
            end
            U_MUL_300:
            begin
                mul_a = MUL_A_BITS'(err_reg);
                mul_b = MUL_B_BITS'(P_GAIN);
            end
            U_MUL_SEEK:
            begin
                mul_a = acc_reg[MUL_A_BITS-1:0];
                mul_b = signed'(MUL_B_BITS'(seek_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // divider: by 255 for the set word, by speed_max for the ticks
    assign div_start   = (ctrl.uop == U_DIV_SM) || (ctrl.uop == U_DIV_255);
    assign div_divisor = (ctrl.uop == U_DIV_255) ? DIVISOR_BITS'(D_GAIN) : sm;

    spdc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // ------------------------------------------------------------------
    // datapath register updates
    // ------------------------------------------------------------------
    always_comb
    begin
        prev_next      = prev_reg;
        target_next    = target_reg;
        seek_next      = seek_reg;
        vel_next       = vel_reg;
        err_next       = err_reg;
        dterm_next     = dterm_reg;
        acc_next       = acc_reg;
        drive_next     = drive_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (ctrl.uop)
            U_NOP: ;
            U_VEL:
            begin
                vel_next    = vel_diff;
                prev_next   = smp_reg;
                target_next = clamp_t;
            end
            U_WRAP:
            begin
                vel_next = vel_adj[STATE_BITS-1:0];
                err_next = target_reg - smp_reg;
            end
            U_DT_PRE:   acc_next = ACC_BITS'(seek_sel - 18'(vel_reg));
            U_MUL_255:  acc_next = mul_p;
            U_MUL_300:  acc_next = mul_p;
            U_MUL_SEEK: acc_next = mul_p;
            U_MUL_SPD:  acc_next = mul_p;
            U_DIV_SM:   ;
            U_DIV_255:  ;
            U_DT_SAT:
            begin
                // saturate to 16 bits, no d term near the target
                if (dt_band)
                begin
                    dterm_next = '0;
                end
                else if (div_quo > ACC_BITS'(32767))
                begin
                    dterm_next = 16'sh7fff;
                end
                else if (div_quo < -ACC_BITS'(32768))
                begin
                    dterm_next = 16'sh8000;
                end
                else
                begin
                    dterm_next = div_quo[STATE_BITS-1:0];
                end
            end
            U_LIMIT:    acc_next = limited;
            U_ADD_D:    acc_next = div_quo + (ACC_BITS'(dterm_reg) <<< DRIVE_SHIFT);
            U_CLEAR:    acc_next = '0;
            U_OUT:
            begin
                drive_next     = scaled[DRIVE_BITS-1:0];
                out_valid_next = 1'b1;
            end
            U_SET:
            begin
                seek_next   = div_quo[SEEK_BITS-1:0];
                target_next = tgt_in_reg;
            end
        endcase
    end

    // control and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_IDLE;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            target_reg    <= '0;
            seek_reg      <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            prev_reg      <= prev_next;
            target_reg    <= target_next;
            seek_reg      <= seek_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= operation;
            tgt_in_reg <= target_position;
            spd_in_reg <= command_speed;
            smp_reg    <= signed'(STATE_BITS'(position_sample));
        end
        vel_reg   <= vel_next;
        err_reg   <= err_next;
        dterm_reg <= dterm_next;
        acc_reg   <= acc_next;
        drive_reg <= drive_next;
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

endmodule
